FILE: hdl/kcl_pkg.sv
// Shared types and constants for the key click and long-press detector.
// Used by kcl_csr, kcl_engine and key_click_longpress_detector_top.
`default_nettype none

package kcl_pkg;

   localparam int NUM_KEYS  = 4;
   localparam int KEY_W     = 2;
   localparam int TIME_W    = 32;
   localparam int CFG_W     = 24;
   localparam int MASK_W    = 4;
   localparam int CNT_W     = 7;
   localparam int CODE_W    = 3;
   localparam int CSR_IDX_W = 3;
   localparam int REQ_W     = 40;
   localparam int RSP_W     = 16;

   localparam logic [CNT_W-1:0] CLICK_MAX = 7'd127;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLICK_TMO   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_MASK = 3'd4;

   localparam logic [CFG_W-1:0]  DEBOUNCE_RST    = 24'd30000;
   localparam logic [CFG_W-1:0]  LONG_PRESS_RST  = 24'd600000;
   localparam logic [CFG_W-1:0]  REPEAT_RST      = 24'd100000;
   localparam logic [CFG_W-1:0]  CLICK_TMO_RST   = 24'd400000;
   localparam logic [MASK_W-1:0] ACTIVE_MASK_RST = 4'hF;

   typedef enum logic [CODE_W-1:0] {
      EV_NONE         = 3'd0,
      EV_LONG_PRESS   = 3'd1,
      EV_LONG_REPEAT  = 3'd2,
      EV_LONG_RELEASE = 3'd3,
      EV_MULTI_CLICK  = 3'd4
   } event_code_type;

   typedef struct packed {
      logic [CFG_W-1:0]  debounce;
      logic [CFG_W-1:0]  hold_limit;
      logic [CFG_W-1:0]  repeat_ival;
      logic [CFG_W-1:0]  click_tmo;
      logic [MASK_W-1:0] active_mask;
   } cfg_type;

   typedef struct packed {
      logic [KEY_W-1:0]  key_index;
      logic              pin_level;
      logic [TIME_W-1:0] now_us;
   } item_type;

   typedef struct packed {
      logic [KEY_W-1:0] event_key;
      event_code_type   event_code;
      logic [CNT_W-1:0] click_count;
   } result_type;

endpackage

`default_nettype wire

FILE: hdl/kcl_csr.sv
// Configuration registers of the key detector, written through the csr channel.
// Depends on kcl_pkg.
`default_nettype none

module kcl_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [kcl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [kcl_pkg::CFG_W-1:0]      csr_data,
   output kcl_pkg::cfg_type                    cfg
);

   kcl_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce    <= kcl_pkg::DEBOUNCE_RST;
         cfg_ff.hold_limit  <= kcl_pkg::LONG_PRESS_RST;
         cfg_ff.repeat_ival <= kcl_pkg::REPEAT_RST;
         cfg_ff.click_tmo   <= kcl_pkg::CLICK_TMO_RST;
         cfg_ff.active_mask <= kcl_pkg::ACTIVE_MASK_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            kcl_pkg::CSR_DEBOUNCE:    cfg_ff.debounce    <= csr_data;
            kcl_pkg::CSR_LONG_PRESS:  cfg_ff.hold_limit  <= csr_data;
            kcl_pkg::CSR_REPEAT:      cfg_ff.repeat_ival <= csr_data;
            kcl_pkg::CSR_CLICK_TMO:   cfg_ff.click_tmo   <= csr_data;
            kcl_pkg::CSR_ACTIVE_MASK: cfg_ff.active_mask <= csr_data[kcl_pkg::MASK_W-1:0];
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: hdl/kcl_engine.sv
// Per-key state registers and the event decision for one item.
// Depends on kcl_pkg; state is updated when the top level commits the item.
`default_nettype none

module kcl_engine (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire kcl_pkg::cfg_type  cfg,
   input  wire kcl_pkg::item_type item,
   input  wire logic          commit,
   output kcl_pkg::result_type result
);

   localparam int KEY_CNT_W = kcl_pkg::KEY_W + 1;

   logic                          held_ff      [kcl_pkg::NUM_KEYS];
   logic                          long_ff      [kcl_pkg::NUM_KEYS];
   logic [kcl_pkg::CNT_W-1:0]     clicks_ff    [kcl_pkg::NUM_KEYS];
   logic [kcl_pkg::TIME_W-1:0]    start_ff     [kcl_pkg::NUM_KEYS];
   logic [kcl_pkg::TIME_W-1:0]    release_ff   [kcl_pkg::NUM_KEYS];
   logic [kcl_pkg::TIME_W-1:0]    rep_ff       [kcl_pkg::NUM_KEYS];

   logic                          held_in;
   logic                          long_in;
   logic [kcl_pkg::CNT_W-1:0]     clicks_in;
   logic [kcl_pkg::TIME_W-1:0]    start_in;
   logic [kcl_pkg::TIME_W-1:0]    release_in;
   logic [kcl_pkg::TIME_W-1:0]    rep_in;

   logic                          key_ok;
   logic                          pressed;
   logic                          cur_held;
   logic                          cur_long;
   logic [kcl_pkg::CNT_W-1:0]     cur_clicks;
   logic [kcl_pkg::TIME_W-1:0]    hold_span;
   logic [kcl_pkg::TIME_W-1:0]    idle_span;
   logic [kcl_pkg::TIME_W-1:0]    rep_span;
   kcl_pkg::event_code_type       code;
   logic [kcl_pkg::CNT_W-1:0]     count;

   assign key_ok     = {1'b0, item.key_index} < KEY_CNT_W'(kcl_pkg::NUM_KEYS);
   assign pressed    = item.pin_level == cfg.active_mask[item.key_index];
   assign cur_held   = held_ff[item.key_index];
   assign cur_long   = long_ff[item.key_index];
   assign cur_clicks = clicks_ff[item.key_index];
   // Hold and idle spans include both end samples; all spans wrap at TIME_W.
   assign hold_span  = item.now_us - start_ff[item.key_index] + 32'd1;
   assign idle_span  = item.now_us - release_ff[item.key_index] + 32'd1;
   assign rep_span   = item.now_us - rep_ff[item.key_index];

   always_comb begin
      held_in    = cur_held;
      long_in    = cur_long;
      clicks_in  = cur_clicks;
      start_in   = start_ff[item.key_index];
      release_in = release_ff[item.key_index];
      rep_in     = rep_ff[item.key_index];
      code       = kcl_pkg::EV_NONE;
      count      = '0;
      if (key_ok) begin
         if (cur_held) begin
            if (pressed) begin
               if (hold_span >= {8'd0, cfg.hold_limit}) begin
                  if (cur_clicks == '0 && !cur_long) begin
                     long_in = 1'b1;
                     rep_in  = item.now_us;
                     code    = kcl_pkg::EV_LONG_PRESS;
                  end else if (cur_long && rep_span >= {8'd0, cfg.repeat_ival}) begin
                     rep_in  = item.now_us;
                     code    = kcl_pkg::EV_LONG_REPEAT;
                  end
               end
            end else begin
               held_in = 1'b0;
               if (hold_span > {8'd0, cfg.debounce}) begin
                  if (cur_long) begin
                     code      = kcl_pkg::EV_LONG_RELEASE;
                     long_in   = 1'b0;
                     clicks_in = '0;
                  end else begin
                     if (cur_clicks != kcl_pkg::CLICK_MAX) begin
                        clicks_in = cur_clicks + 7'd1;
                     end
                     release_in = item.now_us;
                  end
               end
            end
         end else if (pressed) begin
            held_in  = 1'b1;
            start_in = item.now_us;
         end else if (cur_clicks != '0 || cur_long) begin
            // A timeout with no clicks only drops a stale long flag.
            if (idle_span > {8'd0, cfg.click_tmo}) begin
               if (cur_clicks != '0) begin
                  code  = kcl_pkg::EV_MULTI_CLICK;
                  count = cur_clicks;
               end
               clicks_in = '0;
               long_in   = 1'b0;
            end
         end
      end
   end

   assign result.event_key   = item.key_index;
   assign result.event_code  = code;
   assign result.click_count = count;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < kcl_pkg::NUM_KEYS; k++) begin
            held_ff[k]    <= 1'b0;
            long_ff[k]    <= 1'b0;
            clicks_ff[k]  <= '0;
            start_ff[k]   <= '0;
            release_ff[k] <= '0;
            rep_ff[k]     <= '0;
         end
      end else if (commit && key_ok) begin
         held_ff[item.key_index]    <= held_in;
         long_ff[item.key_index]    <= long_in;
         clicks_ff[item.key_index]  <= clicks_in;
         start_ff[item.key_index]   <= start_in;
         release_ff[item.key_index] <= release_in;
         rep_ff[item.key_index]     <= rep_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/key_click_longpress_detector_top.sv
// Top level of the key click and long-press detector: input and result registers.
// Depends on kcl_pkg, kcl_csr and kcl_engine.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_tvalid/req_tready  req_tdata: key_index, pin_level, now_us
//   rsp_      out        rsp_tvalid/rsp_tready  rsp_tdata: event_key, event_code, click_count
//   csr_      in         csr_valid/csr_ready    csr_index, csr_data
//
// One item per clock cycle while the result channel is not stalled; each item gives exactly one result.
// The decision for an item is made in the cycle it leaves the input register, so
// back-to-back items on the same key see each other's state updates.
// Synchronous active-high reset clears all key state and restores register defaults.
// A stalled result holds in the output register while one more item waits at the input.
`default_nettype none

module key_click_longpress_detector_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // [1:0] key_index, [2] pin_level, [34:3] now_us, [39:35] zero
   input  wire logic [kcl_pkg::REQ_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [1:0] event_key, [4:2] event_code, [11:5] click_count, [15:12] zero
   output logic [kcl_pkg::RSP_W-1:0]          rsp_tdata,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [kcl_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [kcl_pkg::CFG_W-1:0]     csr_data
);

   kcl_pkg::cfg_type    cfg;
   kcl_pkg::item_type   item_ff;
   kcl_pkg::item_type   item_in;
   kcl_pkg::result_type result;
   kcl_pkg::result_type result_ff;
   logic                in_valid_ff;
   logic                out_valid_ff;
   logic                advance;
   logic                commit;

   assign item_in.key_index = req_tdata[1:0];
   assign item_in.pin_level = req_tdata[2];
   assign item_in.now_us    = req_tdata[34:3];

   assign advance    = !out_valid_ff || rsp_tready;
   assign commit     = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   kcl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   kcl_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (item_ff),
      .commit (commit),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
      if (commit) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, result_ff.click_count, result_ff.event_code, result_ff.event_key};

   a_key_follows : assert property (@(posedge clock) disable iff (reset)
      commit |=> (result_ff.event_key == $past(item_ff.key_index)))
      else $error("result key does not match the committed item");

   a_count_only_on_click : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (result_ff.event_code == kcl_pkg::EV_MULTI_CLICK ||
                        result_ff.click_count == '0))
      else $error("click count set on a non-click event");

   a_full_blocks_input : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("input accepted while both stages are full");

   a_commit_fills_output : assert property (@(posedge clock) disable iff (reset)
      commit |=> out_valid_ff)
      else $error("committed item did not reach the output register");

endmodule

`default_nettype wire

FILE: tb/kcl_event_checker.sv
// Checker for the key click and long-press detector: follows the three channels,
// predicts the event of every accepted item and compares it with the result channel.
// Depends on kcl_pkg only.

module kcl_event_checker
   import kcl_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [RSP_W-1:0]     rsp_tdata,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   output int                   fail_count,
   output int                   pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   cfg_type           cur_cfg;
   logic              key_held   [NUM_KEYS];
   logic [TIME_W-1:0] press_at   [NUM_KEYS];
   logic [TIME_W-1:0] release_at [NUM_KEYS];
   logic [CNT_W-1:0]  clicks_waiting [NUM_KEYS];
   logic              long_seen  [NUM_KEYS];
   logic [TIME_W-1:0] repeat_at  [NUM_KEYS];
   result_type        expected_events [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   task automatic flag_error(input string msg);
      $display("%0t ns  mismatch: %s", $time, msg);
      fail_count++;
   endtask

   // Works out the event of one item and moves that key's state along.
   function automatic result_type predict_key_event(input logic [KEY_W-1:0] k,
                                                    input logic pin,
                                                    input logic [TIME_W-1:0] now);
      result_type        ev;
      logic              pressed;
      logic [TIME_W-1:0] span;
      ev.event_key   = k;
      ev.event_code  = EV_NONE;
      ev.click_count = '0;
      pressed = (pin == cur_cfg.active_mask[k]);
      if (key_held[k]) begin
         span = now - press_at[k] + 32'd1;
         if (pressed) begin
            if (span >= {8'd0, cur_cfg.hold_limit}) begin
               if (clicks_waiting[k] == '0 && !long_seen[k]) begin
                  long_seen[k]  = 1'b1;
                  repeat_at[k]  = now;
                  ev.event_code = EV_LONG_PRESS;
               end else if (long_seen[k] &&
                            (now - repeat_at[k]) >= {8'd0, cur_cfg.repeat_ival}) begin
                  repeat_at[k]  = now;
                  ev.event_code = EV_LONG_REPEAT;
               end
            end
         end else begin
            key_held[k] = 1'b0;
            if (span > {8'd0, cur_cfg.debounce}) begin
               if (long_seen[k]) begin
                  ev.event_code     = EV_LONG_RELEASE;
                  long_seen[k]      = 1'b0;
                  clicks_waiting[k] = '0;
               end else begin
                  if (clicks_waiting[k] != CLICK_MAX)
                     clicks_waiting[k] = clicks_waiting[k] + 1'b1;
                  release_at[k] = now;
               end
            end
         end
      end else if (pressed) begin
         key_held[k] = 1'b1;
         press_at[k] = now;
      end else if (clicks_waiting[k] != '0 || long_seen[k]) begin
         span = now - release_at[k] + 32'd1;
         if (span > {8'd0, cur_cfg.click_tmo}) begin
            // A run closed with no counted clicks (stale long flag) is cleared silently.
            if (clicks_waiting[k] != '0) begin
               ev.event_code  = EV_MULTI_CLICK;
               ev.click_count = clicks_waiting[k];
            end
            clicks_waiting[k] = '0;
            long_seen[k]      = 1'b0;
         end
      end
      return ev;
   endfunction

   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         cur_cfg.debounce    = DEBOUNCE_RST;
         cur_cfg.hold_limit  = LONG_PRESS_RST;
         cur_cfg.repeat_ival = REPEAT_RST;
         cur_cfg.click_tmo   = CLICK_TMO_RST;
         cur_cfg.active_mask = ACTIVE_MASK_RST;
         for (int i = 0; i < NUM_KEYS; i++) begin
            key_held[i]       = 1'b0;
            press_at[i]       = '0;
            release_at[i]     = '0;
            clicks_waiting[i] = '0;
            long_seen[i]      = 1'b0;
            repeat_at[i]      = '0;
         end
         expected_events.delete();
         pending_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEBOUNCE:    cur_cfg.debounce    = csr_data;
               CSR_LONG_PRESS:  cur_cfg.hold_limit  = csr_data;
               CSR_REPEAT:      cur_cfg.repeat_ival = csr_data;
               CSR_CLICK_TMO:   cur_cfg.click_tmo   = csr_data;
               CSR_ACTIVE_MASK: cur_cfg.active_mask = csr_data[MASK_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            expected_events.push_back(predict_key_event(req_tdata[1:0], req_tdata[2],
                                                        req_tdata[34:3]));
            pending_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_events.size() == 0) begin
               flag_error($sformatf("result %h with no item outstanding", rsp_tdata));
            end else begin
               want = expected_events.pop_front();
               pending_count--;
               if (rsp_tdata[1:0] !== want.event_key)
                  flag_error($sformatf("event_key got %0d, expected %0d",
                                       rsp_tdata[1:0], want.event_key));
               if (rsp_tdata[4:2] !== want.event_code)
                  flag_error($sformatf("event_code on key %0d got %0d, expected %s",
                                       want.event_key, rsp_tdata[4:2],
                                       want.event_code.name()));
               if (rsp_tdata[11:5] !== want.click_count)
                  flag_error($sformatf("click_count on key %0d got %0d, expected %0d",
                                       want.event_key, rsp_tdata[11:5], want.click_count));
            end
         end
      end
   end

endmodule

FILE: tb/tb_key_click_longpress_detector_top.sv
// Testbench top for key_click_longpress_detector_top: clock, reset, key samples,
// register writes and result back-pressure. Depends on kcl_pkg, kcl_event_checker and the RTL.

module tb_key_click_longpress_detector_top;

   timeunit 1ns;
   timeprecision 1ps;

   import kcl_pkg::*;

   localparam int LONG_HOLD = 200;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata  = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CFG_W-1:0]     csr_data   = '0;

   int fail_count;
   int pending_count;

   // Register values as last written; used to aim time steps at the thresholds and to pick pin levels.
   logic [CFG_W-1:0]  deb_us     = DEBOUNCE_RST;
   logic [CFG_W-1:0]  long_us    = LONG_PRESS_RST;
   logic [CFG_W-1:0]  rep_us     = REPEAT_RST;
   logic [CFG_W-1:0]  tmo_us     = CLICK_TMO_RST;
   logic [MASK_W-1:0] level_mask = ACTIVE_MASK_RST;

   logic [TIME_W-1:0] stamp_us = '0;
   int                burst_left = 0;
   int                items_sent = 0;
   logic              hold_off_request = 1'b0;

   key_click_longpress_detector_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   kcl_event_checker u_event_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("** key_click_longpress_detector_top: FAILED **");
      $finish;
   end

   // Result side: stall modes that change at random, plus a long
   // hold-off on request so that the block fills and stops taking items.
   initial begin : rsp_stall_pattern
      int mode;
      int left;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 2);
               left = $urandom_range(8, 64);
            end
            left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               default: rsp_tready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Offers one item and returns at the edge that accepts it.
   task automatic send_item(input logic [KEY_W-1:0] k, input logic pin,
                            input logic [TIME_W-1:0] t);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, t, pin, k};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic key_sample(input logic [KEY_W-1:0] k, input logic pressed);
      send_item(k, pressed ? level_mask[k] : ~level_mask[k], stamp_us);
   endtask

   // A step just below, at, or just above a threshold, or somewhere around it.
   function automatic logic [TIME_W-1:0] around(input logic [TIME_W-1:0] base);
      case ($urandom_range(0, 4))
         0: return (base == '0) ? base : base - 1;
         1: return base;
         2: return base + 1;
         3: return $urandom_range(0, base);
         default: return base + $urandom_range(0, base);
      endcase
   endfunction

   task automatic drain_results;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] lng,
                            input logic [CFG_W-1:0] rep, input logic [CFG_W-1:0] tmo,
                            input logic [MASK_W-1:0] mask);
      // An index past the last register must leave everything unchanged.
      write_reg(CSR_ACTIVE_MASK + 3'($urandom_range(1, 3)), 24'($urandom));
      write_reg(CSR_DEBOUNCE, deb);
      write_reg(CSR_LONG_PRESS, lng);
      write_reg(CSR_REPEAT, rep);
      write_reg(CSR_CLICK_TMO, tmo);
      write_reg(CSR_ACTIVE_MASK, {20'($urandom), mask});
      csr_valid <= 1'b0;
      deb_us     = deb;
      long_us    = lng;
      rep_us     = rep;
      tmo_us     = tmo;
      level_mask = mask;
   endtask

   // A run of clicks closed by an idle sample past the timeout. A firm run
   // always holds just past the debounce time and keeps gaps short.
   task automatic run_clicks(input logic [KEY_W-1:0] k, input int n, input logic firm);
      for (int i = 0; i < n; i++) begin
         key_sample(k, 1'b1);
         stamp_us += firm ? {8'd0, deb_us} + 1 : around({8'd0, deb_us});
         key_sample(k, 1'b0);
         if (i < n - 1) begin
            stamp_us += firm ? 32'd1 : 32'($urandom_range(0, tmo_us));
            if (!firm && $urandom_range(0, 3) == 0)
               key_sample(k, 1'b0);
         end
      end
      stamp_us += around({8'd0, tmo_us});
      key_sample(k, 1'b0);
      stamp_us += {8'd0, tmo_us} + 2;
      key_sample(k, 1'b0);
   endtask

   task automatic run_long_hold(input logic [KEY_W-1:0] k);
      key_sample(k, 1'b1);
      stamp_us += around({8'd0, long_us});
      key_sample(k, 1'b1);
      repeat ($urandom_range(0, 5)) begin
         stamp_us += around({8'd0, rep_us});
         key_sample(k, 1'b1);
      end
      stamp_us += $urandom_range(0, deb_us);
      key_sample(k, 1'b0);
      if ($urandom_range(0, 1) == 1) begin
         stamp_us += {8'd0, tmo_us} + 2;
         key_sample(k, 1'b0);
      end
   endtask

   task automatic run_bounce(input logic [KEY_W-1:0] k);
      key_sample(k, 1'b1);
      stamp_us += $urandom_range(0, deb_us);
      key_sample(k, 1'b0);
   endtask

   task automatic send_stray;
      if ($urandom_range(0, 1) == 1) begin
         stamp_us += $urandom_range(0, 2 * tmo_us + 2);
         send_item(2'($urandom_range(0, NUM_KEYS - 1)), 1'($urandom), stamp_us);
      end else begin
         send_item(2'($urandom_range(0, NUM_KEYS - 1)), 1'($urandom), $urandom);
      end
   endtask

   task automatic run_directed;
      logic [TIME_W-1:0] start;
      // Reset settings: every key is pressed at pin level 1.
      stamp_us = 32'h1000_0000;
      key_sample(0, 1'b1);               // press shorter than the debounce time
      stamp_us += 10;
      key_sample(0, 1'b0);
      stamp_us += 1000;                  // one click, then the run times out
      key_sample(0, 1'b1);
      stamp_us += 50000;
      key_sample(0, 1'b0);
      stamp_us += 500000;
      key_sample(0, 1'b0);
      key_sample(1, 1'b1);               // long press, one repeat, long release
      stamp_us += 600000;
      key_sample(1, 1'b1);
      stamp_us += 100000;
      key_sample(1, 1'b1);
      stamp_us += 5;
      key_sample(1, 1'b0);
      // Long press whose release comes too soon to count: the flag stays set
      // and is dropped silently when the idle timeout runs out.
      start = stamp_us;
      key_sample(2, 1'b1);
      stamp_us += 700000;
      key_sample(2, 1'b1);
      stamp_us = start;
      key_sample(2, 1'b0);
      stamp_us = start + 800000;
      key_sample(2, 1'b0);
      // A long hold after a click raises nothing and counts as a second click.
      key_sample(3, 1'b1);
      stamp_us += 40000;
      key_sample(3, 1'b0);
      stamp_us += 1000;
      key_sample(3, 1'b1);
      stamp_us += 700000;
      key_sample(3, 1'b1);
      stamp_us += 10;
      key_sample(3, 1'b0);
      stamp_us += 400000;
      key_sample(3, 1'b0);
      // A click across the wrap of the timestamp.
      stamp_us = 32'hFFFF_FFFF;
      key_sample(0, 1'b1);
      stamp_us = '0;
      key_sample(1, 1'b0);
      stamp_us += 40000;
      key_sample(0, 1'b0);
      stamp_us += 500000;
      key_sample(0, 1'b0);
   endtask

   initial begin : stimulus
      int target;
      int pick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int phase = 0; items_sent < 950; phase++) begin
         if (phase > 0) begin
            drain_results();
            case (phase)
               1: configure(24'd5, 24'd40, 24'd10, 24'd30, 4'($urandom));
               2: configure('0, '0, '0, '0, '0);
               3: configure('1, '1, '1, '1, '1);
               default: begin
                  if (phase % 3 == 0)
                     configure(24'($urandom), 24'($urandom), 24'($urandom),
                               24'($urandom), 4'($urandom));
                  else
                     configure(24'($urandom_range(0, 300)), 24'($urandom_range(0, 3000)),
                               24'($urandom_range(0, 800)), 24'($urandom_range(0, 2000)),
                               4'($urandom));
               end
            endcase
         end
         if (phase == 1 || phase == 4)
            hold_off_request = 1'b1;
         // The click counter has to saturate at least once.
         if (phase == 1)
            run_clicks(2'($urandom_range(0, NUM_KEYS - 1)), 130, 1'b1);
         target = items_sent + 110;
         while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
               run_clicks(2'($urandom_range(0, NUM_KEYS - 1)), $urandom_range(1, 4), 1'b0);
            else if (pick < 65)
               run_long_hold(2'($urandom_range(0, NUM_KEYS - 1)));
            else if (pick < 78)
               run_bounce(2'($urandom_range(0, NUM_KEYS - 1)));
            else
               send_stray();
         end
      end
      drain_results();
      if (fail_count == 0 && pending_count == 0)
         $display("** key_click_longpress_detector_top: PASSED **");
      else
         $display("** key_click_longpress_detector_top: FAILED **");
      $finish;
   end

endmodule
